// ===== rtl/core/vsb_pkg.sv =====
// shared types, constants and hash helper for the vertex signature builder
package vsb_pkg;

    localparam int SIG_WORDS = 16;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
    localparam logic [31:0] LEN_ONE = 32'd4;
    localparam logic [31:0] LEN_TWO = 32'd8;
    localparam logic [4:0]  NIBBLE_MOD = 5'd15;

    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_INCOMING = 2'd1;
    localparam logic [1:0] OP_OUTGOING = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    typedef enum logic [2:0] {
        ENT_NONE  = 3'b001,
        ENT_START = 3'b010,
        ENT_BUMP  = 3'b100
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [3:0]  word;
        logic [4:0]  pos;
        logic        last;
    } entry_t;

    function automatic logic [31:0] mul_mix(input logic [31:0] a);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, MIX_MUL};
        return p[31:0];
    endfunction

endpackage

// ===== rtl/core/vsb_front.sv =====
// front end: accepts requests, runs the hash on a shared multiplier, reduces it to a slot or a label bit
module vsb_front #(
    parameter int LABEL_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     hash_seed,
    input  logic            item_valid,
    output logic            item_ready,
    input  logic [1:0]      operation,
    input  logic [31:0]     label_value,
    input  logic [30:0]     edge_label,
    input  logic            last_of_vertex,
    output logic            push_valid,
    input  logic            push_ready,
    output vsb_pkg::entry_t push_entry
);
    import vsb_pkg::*;

    localparam logic [6:0]  LB    = 7'(LABEL_BITS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LABEL_BITS));

    typedef enum logic [7:0] {
        F_IDLE = 8'b00000001,
        F_KA   = 8'b00000010,
        F_KB   = 8'b00000100,
        F_HM   = 8'b00001000,
        F_FIN  = 8'b00010000,
        F_RED  = 8'b00100000,
        F_MOD  = 8'b01000000,
        F_PUSH = 8'b10000000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic         widx_reg, widx_next;
    logic [1:0]   op_reg, op_next;
    logic         last_reg, last_next;
    logic [31:0]  w0_reg, w0_next;
    logic [31:0]  w1_reg, w1_next;
    logic [31:0]  h_reg, h_next;
    logic [31:0]  k_reg, k_next;
    entry_t       entry_reg, entry_next;

    logic [31:0]  cur_w;
    logic [31:0]  mul_in;
    logic [31:0]  prod;
    logic         is_start;
    logic [6:0]   nib_sum;
    logic [4:0]   fold;
    logic [4:0]   digit;
    logic [3:0]   slot_word;
    logic [63:0]  recip_prod;
    logic [13:0]  q_times_lb;
    logic [6:0]   rem_raw;
    logic [6:0]   rem_fix;

    // slot select: hash mod 240 = 16 * ((hash >> 4) mod 15) + (hash mod 16)
    always_comb
    begin
        nib_sum = '0;
        for (int i = 1; i < 8; i++)
        begin
            nib_sum = nib_sum + 7'(h_reg[i*4 +: 4]);
        end
        fold      = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        digit     = (fold >= NIBBLE_MOD) ? (fold - NIBBLE_MOD) : fold;
        slot_word = 4'(digit) + 4'd1;
    end

    // label bit: reciprocal quotient estimate, low remainder bits, one correction
    always_comb
    begin
        recip_prod = {32'd0, h_reg} * {32'd0, RECIP};
        q_times_lb = {7'd0, k_reg[6:0]} * {7'd0, LB};
        rem_raw    = h_reg[6:0] - q_times_lb[6:0];
        rem_fix    = (rem_raw >= LB) ? (rem_raw - LB) : rem_raw;
    end

    always_comb
    begin
        cur_w    = widx_reg ? w1_reg : w0_reg;
        is_start = (op_reg == OP_START);
        unique case (state_reg)
            F_KA:    mul_in = cur_w;
            F_KB:    mul_in = k_reg ^ (k_reg >> 24);
            F_FIN:   mul_in = h_reg ^ (h_reg >> 13);
            default: mul_in = h_reg;
        endcase
        prod = mul_mix(mul_in);
    end

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        entry_next = entry_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (item_valid)
                begin
                    op_next   = operation;
                    last_next = last_of_vertex;
                    w0_next   = label_value;
                    w1_next   = (operation == OP_OUTGOING) ? (32'd0 - {1'b0, edge_label})
                                                           : {1'b0, edge_label};
                    h_next    = hash_seed ^ ((operation == OP_START) ? LEN_ONE : LEN_TWO);
                    widx_next = 1'b0;
                    if (operation == OP_UNUSED)
                    begin
                        entry_next = '{kind: ENT_NONE, word: 4'd0, pos: 5'd0,
                                       last: last_of_vertex};
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_KA;
                    end
                end
            end
            F_KA:
            begin
                k_next     = prod;
                state_next = F_KB;
            end
            F_KB:
            begin
                k_next     = prod;
                state_next = F_HM;
            end
            F_HM:
            begin
                h_next = prod ^ k_reg;
                if (is_start || widx_reg)
                begin
                    state_next = F_FIN;
                end
                else
                begin
                    widx_next  = 1'b1;
                    state_next = F_KA;
                end
            end
            F_FIN:
            begin
                h_next     = prod ^ (prod >> 15);
                state_next = F_RED;
            end
            F_RED:
            begin
                if (is_start)
                begin
                    k_next     = recip_prod[63:32];
                    state_next = F_MOD;
                end
                else
                begin
                    entry_next = '{kind: ENT_BUMP, word: slot_word, pos: {h_reg[3:0], 1'b0},
                                   last: last_reg};
                    state_next = F_PUSH;
                end
            end
            F_MOD:
            begin
                entry_next = '{kind: ENT_START, word: 4'd0, pos: rem_fix[4:0],
                               last: last_reg};
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            widx_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        last_reg  <= last_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        h_reg     <= h_next;
        k_reg     <= k_next;
        entry_reg <= entry_next;
    end

    assign item_ready = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_entry = entry_reg;

endmodule

// ===== rtl/core/vsb_queue.sv =====
// small fifo of classified requests between front and back
module vsb_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  vsb_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output vsb_pkg::entry_t pop_entry
);
    import vsb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];

endmodule

// ===== rtl/core/vsb_back.sv =====
// back end: applies slot and label updates to the signature and streams it out
module vsb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  vsb_pkg::entry_t pop_entry,
    output logic            word_valid,
    input  logic            word_ready,
    output logic [3:0]      word_index,
    output logic [31:0]     word_value,
    output logic            last_word
);
    import vsb_pkg::*;

    localparam logic [3:0] IDX_LAST = 4'(SIG_WORDS - 1);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [3:0]   emit_cnt_reg, emit_cnt_next;
    logic [31:0]  sig_reg [SIG_WORDS];
    logic         word_valid_reg;
    logic [3:0]   word_index_reg;
    logic [31:0]  word_value_reg;
    logic         last_word_reg;

    logic [3:0]   rd_addr;
    logic [31:0]  rd_word;
    logic [1:0]   cur;
    logic [31:0]  new_word;
    logic         take;
    logic         out_free;
    logic         emitting;

    always_comb
    begin
        emitting = (state_reg == B_EMIT);
        rd_addr  = emitting ? emit_cnt_reg : pop_entry.word;
        rd_word  = sig_reg[rd_addr];
        cur      = 2'(rd_word >> pop_entry.pos);
        new_word = rd_word | ({30'd0, (cur == 2'd0) ? 2'b01 : 2'b11} << pop_entry.pos);
        take     = pop_valid && (state_reg == B_IDLE);
        out_free = !word_valid_reg || word_ready;
    end

    always_comb
    begin
        state_next    = state_reg;
        emit_cnt_next = emit_cnt_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take && pop_entry.last)
                begin
                    emit_cnt_next = 4'd0;
                    state_next    = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    emit_cnt_next = emit_cnt_reg + 4'd1;
                    if (emit_cnt_reg == IDX_LAST)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            emit_cnt_reg   <= 4'd0;
            word_valid_reg <= 1'b0;
            for (int i = 0; i < SIG_WORDS; i++)
            begin
                sig_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            emit_cnt_reg <= emit_cnt_next;
            if (out_free)
            begin
                word_valid_reg <= emitting;
            end
            if (take)
            begin
                unique case (pop_entry.kind)
                    ENT_START:
                    begin
                        for (int i = 1; i < SIG_WORDS; i++)
                        begin
                            sig_reg[i] <= '0;
                        end
                        sig_reg[0] <= 32'd1 << pop_entry.pos;
                    end
                    ENT_BUMP:
                    begin
                        sig_reg[pop_entry.word] <= new_word;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emitting && out_free)
        begin
            word_index_reg <= emit_cnt_reg;
            word_value_reg <= rd_word;
            last_word_reg  <= (emit_cnt_reg == IDX_LAST);
        end
    end

    assign pop_ready  = (state_reg == B_IDLE);
    assign word_valid = word_valid_reg;
    assign word_index = word_index_reg;
    assign word_value = word_value_reg;
    assign last_word  = last_word_reg;

endmodule

// ===== rtl/core/vertex_signature_builder.sv =====
// top level of the vertex signature builder: seed register, front, queue, back
// front: one request at a time; the hash runs on one shared constant multiplier; neighbor
//   requests hash two words, start requests one plus a MOD step; each waits out a full queue
// back: one queued request per cycle while idle; a last request then streams 16 words, one
//   per cycle while word_ready allows, through an output register once in the emit state
// reset (async, active low) clears the seed, the signature words, the queue and all control
module vertex_signature_builder #(
    parameter int LABEL_BITS  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] label_value,
    input  logic [30:0] edge_label,
    input  logic        last_of_vertex,
    output logic        word_valid,
    input  logic        word_ready,
    output logic [3:0]  word_index,
    output logic [31:0] word_value,
    output logic        last_word
);
    import vsb_pkg::*;

    logic [31:0] hash_seed_reg;
    logic        push_valid;
    logic        push_ready;
    entry_t      push_entry;
    logic        pop_valid;
    logic        pop_ready;
    entry_t      pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            hash_seed_reg <= cfg_wdata;
        end
    end

    vsb_front #(
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .hash_seed      (hash_seed_reg),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .label_value    (label_value),
        .edge_label     (edge_label),
        .last_of_vertex (last_of_vertex),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    vsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    vsb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_index (word_index),
        .word_value (word_value),
        .last_word  (last_word)
    );

    // front takes one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("front accepted back-to-back requests");

    // last word of a signature sits at the top index
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && last_word |-> word_index == 4'(SIG_WORDS - 1))
        else $error("last word flagged at wrong index");

    // word 0 holds at most the single label bit
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_index == 4'd0 |-> $onehot0(word_value))
        else $error("label word has more than one bit set");

    // back stops draining the queue while it streams a signature
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready && pop_entry.last |=> !pop_ready)
        else $error("back took a request during emission");

endmodule
